FILE: rtl/cbrf_pkg.sv
`timescale 1ns / 1ps

package cbrf_pkg;

    localparam int WORD_W = 32;
    localparam int F_W = 47;
    localparam int IDX_W = 6;
    localparam int PROD_W = 64;
    localparam int STEP_W = 4;

    localparam int MAX_PASSES_DEF = 40;
    localparam int FRAC_BITS_DEF = 24;

    localparam logic [WORD_W-1:0] TOL_RESET = 32'd16777;

    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SQ_L = 4'd1;
    localparam logic [STEP_W-1:0] STEP_P1_L = 4'd2;
    localparam logic [STEP_W-1:0] STEP_P2_L = 4'd3;
    localparam logic [STEP_W-1:0] STEP_FIN_L = 4'd4;
    localparam logic [STEP_W-1:0] STEP_MID = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SQ_M = 4'd6;
    localparam logic [STEP_W-1:0] STEP_P1_M = 4'd7;
    localparam logic [STEP_W-1:0] STEP_P2_M = 4'd8;
    localparam logic [STEP_W-1:0] STEP_FIN_M = 4'd9;
    localparam logic [STEP_W-1:0] STEP_UPD = 4'd10;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQ,
        OP_P1,
        OP_P2,
        OP_FIN_L,
        OP_MID,
        OP_FIN_M,
        OP_UPD
    } op_t;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_WAIT_IN,
        COND_WAIT_OUT
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c = '{op: OP_NOP, cond: COND_NEXT, target: STEP_IDLE};
        case (step)
            STEP_IDLE:  c = '{op: OP_LOAD,  cond: COND_WAIT_IN,  target: STEP_SQ_L};
            STEP_SQ_L:  c = '{op: OP_SQ,    cond: COND_NEXT,     target: STEP_P1_L};
            STEP_P1_L:  c = '{op: OP_P1,    cond: COND_NEXT,     target: STEP_P2_L};
            STEP_P2_L:  c = '{op: OP_P2,    cond: COND_NEXT,     target: STEP_FIN_L};
            STEP_FIN_L: c = '{op: OP_FIN_L, cond: COND_NEXT,     target: STEP_MID};
            STEP_MID:   c = '{op: OP_MID,   cond: COND_NEXT,     target: STEP_SQ_M};
            STEP_SQ_M:  c = '{op: OP_SQ,    cond: COND_NEXT,     target: STEP_P1_M};
            STEP_P1_M:  c = '{op: OP_P1,    cond: COND_NEXT,     target: STEP_P2_M};
            STEP_P2_M:  c = '{op: OP_P2,    cond: COND_NEXT,     target: STEP_FIN_M};
            STEP_FIN_M: c = '{op: OP_FIN_M, cond: COND_NEXT,     target: STEP_UPD};
            STEP_UPD:   c = '{op: OP_UPD,   cond: COND_WAIT_OUT, target: STEP_MID};
            default:    c = '{op: OP_NOP,   cond: COND_NEXT,     target: STEP_IDLE};
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/cubic_bisection_root_finder_core.sv
`timescale 1ns / 1ps

// Bisection on f(x) = x^3 - x - 1 over signed fixed-point bounds.
// Input channel s_*: one word carries the starting interval. It is taken only
// while the sequencer is between runs, so s_tready is low during a run.
// Output channel m_*: one word per pass, carrying the pass index, the new
// bounds, the midpoint, f at the new lower bound and f at the midpoint.
// m_tlast marks the final word of a run and m_tuser flags a run that ended at
// the pass limit instead of at the tolerance.
// The tolerance register is written through cfg_wr_en and cfg_wr_data and
// should only be changed between runs.
// A run first evaluates f at the lower bound in steps SQ_L to FIN_L. Each
// pass then forms the midpoint, evaluates f there through one shared 33x33
// multiplier, which is used three times per cube, and ends in step UPD.
// A result word sits in an output register; while the receiver stalls, the
// sequencer finishes the next pass and then waits in its update step.
// Reset clears the sequencer, the output valid and the pass count, and sets
// the tolerance to its default.
module cubic_bisection_root_finder_core #(
    parameter int MAX_PASSES = cbrf_pkg::MAX_PASSES_DEF,
    parameter int FRAC_BITS = cbrf_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [31:0]    cfg_wr_data,
    input  logic           s_tvalid,
    output logic           s_tready,
    // start_low, start_high
    input  logic [63:0]    s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // step_index, lower_bound, upper_bound, midpoint, f_at_lower, f_at_mid, pad
    output logic [199:0]   m_tdata,
    output logic           m_tlast,
    // hit_cap
    output logic           m_tuser
);

    localparam int W = cbrf_pkg::WORD_W;
    localparam int FW = cbrf_pkg::F_W;
    localparam int IW = cbrf_pkg::IDX_W;
    localparam int SW = cbrf_pkg::STEP_W;

    cbrf_pkg::ctrl_t ctrl;

    logic [SW-1:0] step_reg;
    logic [SW-1:0] step_next;
    logic [W-1:0] tol_reg;
    logic signed [W-1:0] lower_reg;
    logic signed [W-1:0] upper_reg;
    logic signed [W-1:0] x_reg;
    logic signed [FW-1:0] f_lower_reg;
    logic signed [FW-1:0] f_mid_reg;
    logic [IW-1:0] pass_reg;

    logic out_valid_reg;
    logic [IW-1:0] out_step_reg;
    logic signed [W-1:0] out_lower_reg;
    logic signed [W-1:0] out_upper_reg;
    logic signed [W-1:0] out_mid_reg;
    logic signed [FW-1:0] out_fl_reg;
    logic signed [FW-1:0] out_fm_reg;
    logic out_last_reg;
    logic out_cap_reg;

    logic signed [FW-1:0] f_val;
    logic signed [W:0] sum;
    logic slot_free;
    logic upd_fire;
    logic lower_neg;
    logic lower_pos;
    logic mid_neg;
    logic mid_pos;
    logic opposite;
    logic signed [W-1:0] new_lower;
    logic signed [W-1:0] new_upper;
    logic signed [FW-1:0] new_fl;
    logic signed [W:0] diff;
    logic [W:0] width;
    logic more;
    logic [IW:0] pass_inc;
    logic cap;
    logic row_last;

    assign ctrl = cbrf_pkg::ucode(step_reg);

    cbrf_cubic #(
        .FRAC_BITS(FRAC_BITS)
    ) u_cubic (
        .clk(clk),
        .op(ctrl.op),
        .x(x_reg),
        .f(f_val)
    );

    assign s_tready = (ctrl.cond == cbrf_pkg::COND_WAIT_IN);
    assign slot_free = !out_valid_reg || m_tready;
    assign upd_fire = (ctrl.op == cbrf_pkg::OP_UPD) && slot_free;

    always_comb
    begin
        sum = {lower_reg[W-1], lower_reg} + {upper_reg[W-1], upper_reg};
        lower_neg = f_lower_reg[FW-1];
        lower_pos = !f_lower_reg[FW-1] && (f_lower_reg != '0);
        mid_neg = f_mid_reg[FW-1];
        mid_pos = !f_mid_reg[FW-1] && (f_mid_reg != '0);
        opposite = (lower_neg && mid_pos) || (lower_pos && mid_neg);
        new_lower = opposite ? lower_reg : x_reg;
        new_upper = opposite ? x_reg : upper_reg;
        new_fl = opposite ? f_lower_reg : f_mid_reg;
        diff = {new_lower[W-1], new_lower} - {new_upper[W-1], new_upper};
        width = diff[W] ? unsigned'(-diff) : unsigned'(diff);
        more = width > {1'b0, tol_reg};
        pass_inc = {1'b0, pass_reg} + (IW + 1)'(1);
        cap = more && (pass_inc >= (IW + 1)'(MAX_PASSES));
        row_last = !more || cap;
    end

    always_comb
    begin
        step_next = step_reg;
        case (ctrl.cond)
            cbrf_pkg::COND_NEXT: step_next = ctrl.target;
            cbrf_pkg::COND_WAIT_IN:
            begin
                if (s_tvalid)
                begin
                    step_next = ctrl.target;
                end
            end
            cbrf_pkg::COND_WAIT_OUT:
            begin
                if (slot_free)
                begin
                    step_next = row_last ? cbrf_pkg::STEP_IDLE : ctrl.target;
                end
            end
            default: step_next = cbrf_pkg::STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= cbrf_pkg::STEP_IDLE;
            tol_reg <= cbrf_pkg::TOL_RESET;
            out_valid_reg <= 1'b0;
            pass_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
            if (cfg_wr_en)
            begin
                tol_reg <= cfg_wr_data;
            end
            if (upd_fire)
            begin
                out_valid_reg <= 1'b1;
                pass_reg <= pass_inc[IW-1:0];
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (s_tvalid && s_tready)
            begin
                pass_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            cbrf_pkg::OP_LOAD:
            begin
                if (s_tvalid)
                begin
                    lower_reg <= s_tdata[W-1:0];
                    upper_reg <= s_tdata[2*W-1:W];
                    x_reg <= s_tdata[W-1:0];
                end
            end
            cbrf_pkg::OP_FIN_L: f_lower_reg <= f_val;
            cbrf_pkg::OP_MID: x_reg <= sum[W:1];
            cbrf_pkg::OP_FIN_M: f_mid_reg <= f_val;
            cbrf_pkg::OP_UPD:
            begin
                if (slot_free)
                begin
                    lower_reg <= new_lower;
                    upper_reg <= new_upper;
                    f_lower_reg <= new_fl;
                    out_step_reg <= pass_reg;
                    out_lower_reg <= new_lower;
                    out_upper_reg <= new_upper;
                    out_mid_reg <= x_reg;
                    out_fl_reg <= new_fl;
                    out_fm_reg <= f_mid_reg;
                    out_last_reg <= row_last;
                    out_cap_reg <= cap;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {4'b0000, out_fm_reg, out_fl_reg, out_mid_reg, out_upper_reg,
                      out_lower_reg, out_step_reg};
    assign m_tlast = out_last_reg;
    assign m_tuser = out_cap_reg;

    a_load_starts_cube: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (step_reg == cbrf_pkg::STEP_SQ_L))
        else $error("accepted interval did not start the cube evaluation");

    a_cap_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("pass limit flagged on a word that does not end the run");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, out_step_reg} < (IW + 1)'(MAX_PASSES)))
        else $error("pass index beyond the pass limit");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && row_last) |=> (step_reg == cbrf_pkg::STEP_IDLE))
        else $error("sequencer kept running after the final word");

    a_no_accept_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != cbrf_pkg::STEP_IDLE) |-> !s_tready)
        else $error("input taken in the middle of a run");

endmodule

FILE: rtl/cbrf_cubic.sv
`timescale 1ns / 1ps

module cbrf_cubic #(
    parameter int FRAC_BITS = cbrf_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  cbrf_pkg::op_t                     op,
    input  logic signed [cbrf_pkg::WORD_W-1:0] x,
    output logic signed [cbrf_pkg::F_W-1:0]    f
);

    localparam int W = cbrf_pkg::WORD_W;
    localparam int PW = cbrf_pkg::PROD_W;
    localparam int FULL_W = 2 * PW;
    localparam int SUM_W = cbrf_pkg::F_W + 3;
    localparam logic [FULL_W-1:0] CUBE_CAP = FULL_W'(1) << (cbrf_pkg::F_W);
    localparam logic signed [SUM_W-1:0] F_MAX = (SUM_W'(1) <<< (cbrf_pkg::F_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] F_MIN = -(SUM_W'(1) <<< (cbrf_pkg::F_W - 1));
    localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) <<< FRAC_BITS;

    logic [W-1:0] a_reg;
    logic [PW-1:0] sq_reg;
    logic [PW-1:0] p1_reg;
    logic [PW-1:0] p2_reg;

    logic signed [W:0] opa;
    logic signed [W:0] opb;
    logic signed [2*W+1:0] prod;

    logic [PW-1:0] hi_sum;
    logic [FULL_W-1:0] full;
    logic [FULL_W-1:0] shifted;
    logic [cbrf_pkg::F_W:0] cube;
    logic signed [SUM_W-1:0] cube_s;
    logic signed [SUM_W-1:0] total;

    always_comb
    begin
        opa = {1'b0, sq_reg[W-1:0]};
        opb = {1'b0, a_reg};
        case (op)
            cbrf_pkg::OP_SQ:
            begin
                opa = {x[W-1], x};
                opb = {x[W-1], x};
            end
            cbrf_pkg::OP_P2:
            begin
                opa = {1'b0, sq_reg[PW-1:W]};
                opb = {1'b0, a_reg};
            end
            default:
            begin
                opa = {1'b0, sq_reg[W-1:0]};
                opb = {1'b0, a_reg};
            end
        endcase
        prod = opa * opb;
    end

    always_ff @(posedge clk)
    begin
        case (op)
            cbrf_pkg::OP_SQ:
            begin
                sq_reg <= prod[PW-1:0];
                a_reg <= x[W-1] ? W'(-x) : W'(x);
            end
            cbrf_pkg::OP_P1: p1_reg <= prod[PW-1:0];
            cbrf_pkg::OP_P2: p2_reg <= prod[PW-1:0];
            default: ;
        endcase
    end

    always_comb
    begin
        hi_sum = p2_reg + {{W{1'b0}}, p1_reg[PW-1:W]};
        full = {{W{1'b0}}, hi_sum, p1_reg[W-1:0]};
        shifted = full >> (2 * FRAC_BITS);
        cube = (shifted > CUBE_CAP) ? CUBE_CAP[cbrf_pkg::F_W:0] : shifted[cbrf_pkg::F_W:0];
        cube_s = x[W-1] ? -$signed({2'b00, cube}) : $signed({2'b00, cube});
        total = cube_s - SUM_W'(x) - ONE;
        if (total > F_MAX)
        begin
            f = F_MAX[cbrf_pkg::F_W-1:0];
        end
        else if (total < F_MIN)
        begin
            f = F_MIN[cbrf_pkg::F_W-1:0];
        end
        else
        begin
            f = total[cbrf_pkg::F_W-1:0];
        end
    end

endmodule
